// ===== sv/wildcard_mask_match_macros.svh =====
// assertion macros shared by the wildcard mask matcher rtl
// expects i_clk and i_rst_n in the scope that uses them, no other dependencies
`ifndef WILDCARD_MASK_MATCH_MACROS_SVH
`define WILDCARD_MASK_MATCH_MACROS_SVH

// same-cycle implication, checked out of reset only
`define WMM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset only
`define WMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wmm_pkg.sv =====
// types, constants and helper functions for the wildcard mask matcher
// no dependencies; used by wmm_cell, wmm_ctrl and wildcard_mask_match
package wmm_pkg;

    localparam int MAX_MASK_TOKENS = 64;
    localparam int CNT_W = $clog2(MAX_MASK_TOKENS + 1);
    localparam int IDX_W = $clog2(MAX_MASK_TOKENS);

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ONE  = 8'h3F;
    localparam logic [7:0] CH_ESC  = 8'h5C;

    typedef enum logic [1:0] {
        KIND_MASK_BYTE = 2'd0,
        KIND_MASK_END  = 2'd1,
        KIND_SUBJ_BYTE = 2'd2,
        KIND_SUBJ_END  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        TOK_LIT  = 2'd0,
        TOK_ONE  = 2'd1,
        TOK_STAR = 2'd2
    } t_tok_type;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
    } t_in_beat;

    typedef struct packed {
        logic matched;
        logic mask_overflow;
    } t_out_beat;

    typedef struct packed {
        t_tok_type  kind;
        logic [7:0] ch;
    } t_token;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_token           tok;
    } t_push;

    // tokenizer decisions for the beat on the input
    typedef struct packed {
        t_push            push0;
        t_push            push1;
        logic [CNT_W-1:0] count_n;
        logic             ovf_n;
        logic             from_start;
        logic             load_start;
        logic             step;
    } t_mask_ctl;

    // registered tokenizer state
    typedef struct packed {
        logic             closed;
        logic             esc;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_mask_stat;

    // signals common to the whole row of cells
    typedef struct packed {
        logic       from_start;
        logic       upd_start;
        logic       upd_step;
        logic       casemap;
        logic [7:0] fc;
    } t_row_ctl;

    // signals particular to one cell
    typedef struct packed {
        logic   wr_en;
        t_token wr_tok;
        logic   tok_valid;
        logic   origin;
    } t_cell_ctl;

    function automatic logic [7:0] wmm_fold(input logic [7:0] c, input logic cm);
        logic [7:0] hi;
        begin
            hi = cm ? 8'h5E : 8'h5A;
            if (c >= 8'h41 && c <= hi) begin
                return c + 8'h20;
            end
            return c;
        end
    endfunction

endpackage

// ===== sv/wmm_cell.sv =====
// one mask position of the matcher: token register plus active bit
// depends on wmm_pkg; a row of these forms the automaton
module wmm_cell
    import wmm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_row_ctl  i_row,
    input  t_cell_ctl i_cell,
    input  logic      i_cin,
    input  logic      i_adv,
    output logic      o_cout,
    output logic      o_adv,
    output logic      o_at_end
);

    t_token r_tok;
    logic   r_raw;
    logic   n_raw;
    t_token tok;
    logic   act;
    logic   is_star;
    logic   hit;

    // token as it stands after this beat's writes
    assign tok     = i_cell.wr_en ? i_cell.wr_tok : r_tok;
    // active once the star closure from the left has been applied
    assign act     = (i_row.from_start ? i_cell.origin : r_raw) | i_cin;
    assign is_star = i_cell.tok_valid && (tok.kind == TOK_STAR);
    assign hit     = i_cell.tok_valid && ((tok.kind == TOK_ONE) ||
                     ((tok.kind == TOK_LIT) && (wmm_fold(tok.ch, i_row.casemap) == i_row.fc)));

    assign o_cout   = act & is_star;
    assign o_adv    = act & hit;
    assign o_at_end = act & ~i_cell.tok_valid;

    always_comb begin
        priority if (i_row.upd_start) begin
            n_raw = i_cell.origin;
        end else if (i_row.upd_step) begin
            n_raw = (act & is_star) | i_adv;
        end else begin
            n_raw = r_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cell.wr_en) begin
            r_tok <= i_cell.wr_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= i_cell.origin;
        end else begin
            r_raw <= n_raw;
        end
    end

endmodule

// ===== sv/wmm_ctrl.sv =====
// mask tokenizer: escape handling, token count, overflow and mask open/close
// depends on wmm_pkg; drives the write side of the cell row
module wmm_ctrl
    import wmm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_in_beat   i_in,
    output t_mask_ctl  o_ctl,
    output t_mask_stat o_stat
);

    localparam int CX_W = CNT_W + 1;
    localparam logic [CX_W-1:0] MAX_X = CX_W'(MAX_MASK_TOKENS);

    logic             r_closed;
    logic             r_esc;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;

    logic             n_closed;
    logic             n_esc;
    logic             opening;
    logic             esc_b;
    logic [CNT_W-1:0] cnt_b;
    logic             ovf_b;
    logic             want0;
    logic             want1;
    t_token           tok0;
    logic [7:0]       c;
    t_token           tok1;
    logic [CX_W-1:0]  cnt_x;
    logic [CX_W-1:0]  cnt_x1;
    logic [CX_W-1:0]  cnt_nx;
    logic             fit0;
    logic             fit1;
    logic             add0;
    logic             add1;

    function automatic t_token plain_tok(input logic [7:0] ch);
        t_token t;
        begin
            if (ch == CH_STAR) begin
                t = t_token'{kind: TOK_STAR, ch: 8'h00};
            end else if (ch == CH_ONE) begin
                t = t_token'{kind: TOK_ONE, ch: 8'h00};
            end else begin
                t = t_token'{kind: TOK_LIT, ch: ch};
            end
            return t;
        end
    endfunction

    assign c = i_in.byte_value;

    always_comb begin
        // a mask beat after a closed mask starts a fresh one
        opening = r_closed && ((i_in.kind == KIND_MASK_BYTE) || (i_in.kind == KIND_MASK_END));
        esc_b   = opening ? 1'b0 : r_esc;
        cnt_b   = opening ? '0 : r_count;
        ovf_b   = opening ? 1'b0 : r_ovf;

        want0            = 1'b0;
        want1            = 1'b0;
        tok0             = t_token'{kind: TOK_LIT, ch: CH_ESC};
        tok1             = plain_tok(c);
        n_esc            = esc_b;
        n_closed         = r_closed;
        o_ctl.from_start = 1'b0;
        o_ctl.load_start = 1'b0;
        o_ctl.step       = 1'b0;

        unique case (i_in.kind)
            KIND_MASK_BYTE: begin
                n_closed = 1'b0;
                if (esc_b) begin
                    n_esc = 1'b0;
                    want0 = 1'b1;
                    if (c == CH_ONE || c == CH_STAR) begin
                        tok0 = t_token'{kind: TOK_LIT, ch: c};
                    end else if (c == CH_ESC) begin
                        n_esc = 1'b1;
                    end else begin
                        want1 = 1'b1;
                    end
                end else if (c == CH_ESC) begin
                    n_esc = 1'b1;
                end else begin
                    want0 = 1'b1;
                    tok0  = plain_tok(c);
                end
            end
            KIND_MASK_END: begin
                // trailing backslash stays literal
                want0            = esc_b;
                n_esc            = 1'b0;
                n_closed         = 1'b1;
                o_ctl.load_start = 1'b1;
            end
            KIND_SUBJ_BYTE: begin
                want0            = !r_closed && esc_b;
                n_esc            = 1'b0;
                n_closed         = 1'b1;
                o_ctl.from_start = !r_closed;
                o_ctl.step       = 1'b1;
            end
            KIND_SUBJ_END: begin
                want0            = !r_closed && esc_b;
                n_esc            = 1'b0;
                n_closed         = 1'b1;
                o_ctl.from_start = !r_closed;
                o_ctl.load_start = 1'b1;
            end
        endcase

        cnt_x  = CX_W'(cnt_b);
        cnt_x1 = cnt_x + CX_W'(1);
        fit0   = cnt_x < MAX_X;
        fit1   = cnt_x1 < MAX_X;
        add0   = want0 & fit0;
        add1   = want1 & fit1;
        cnt_nx = cnt_x + CX_W'(add0) + CX_W'(add1);

        o_ctl.push0.en  = add0;
        o_ctl.push0.idx = cnt_x[IDX_W-1:0];
        o_ctl.push0.tok = tok0;
        o_ctl.push1.en  = add1;
        o_ctl.push1.idx = cnt_x1[IDX_W-1:0];
        o_ctl.push1.tok = tok1;
        o_ctl.count_n   = cnt_nx[CNT_W-1:0];
        o_ctl.ovf_n     = ovf_b | (want0 & ~fit0) | (want1 & ~fit1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed <= 1'b1;
            r_esc    <= 1'b0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else if (i_accept) begin
            r_closed <= n_closed;
            r_esc    <= n_esc;
            r_count  <= o_ctl.count_n;
            r_ovf    <= o_ctl.ovf_n;
        end
    end

    assign o_stat.closed = r_closed;
    assign o_stat.esc    = r_esc;
    assign o_stat.count  = r_count;
    assign o_stat.ovf    = r_ovf;

endmodule

// ===== sv/wildcard_mask_match.sv =====
// wildcard mask matcher: one beat per cycle in, result registered and valid in the cycle after subject end is taken
// throughput: 1 beat per clock while results are taken; an untaken result holds off all input
// critical path: star closure rippling across the MAX_MASK_TOKENS+1 cells
// reset (i_rst_n, synchronous): empty closed mask, start position active, casemap ascii
// token registers are not reset; no clearing pass, the block is ready right after reset
`include "wildcard_mask_match_macros.svh"

module wildcard_mask_match
    import wmm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input beats: mask bytes, mask end, subject bytes, subject end
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    // result beats, one per subject end
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    // casemap register write
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam int NCELL = MAX_MASK_TOKENS + 1;

    logic       r_casemap;
    logic       r_out_valid;
    t_out_beat  r_out;

    logic       accept;
    logic       any_end;
    t_mask_ctl  ctl;
    t_mask_stat stat;
    t_row_ctl   row;
    t_cell_ctl  cell_ctl [NCELL];
    logic       w_cin    [NCELL];
    logic       w_adv_in [NCELL];
    logic       w_cout   [NCELL];
    logic       w_adv    [NCELL];
    logic [NCELL-1:0] w_at_end;

    // input is taken while the output register is empty or being drained;
    // a result left waiting holds off every input beat
    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign accept      = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;

    wmm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in_data),
        .o_ctl    (ctl),
        .o_stat   (stat)
    );

    // row-wide control; the subject byte is folded once here
    assign row.from_start = ctl.from_start;
    assign row.upd_start  = accept & ctl.load_start;
    assign row.upd_step   = accept & ctl.step;
    assign row.casemap    = r_casemap;
    assign row.fc         = wmm_fold(i_in_data.byte_value, r_casemap);

    // cell g holds mask position g; the last cell is the end-of-mask position
    // and never holds a token
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic hit0;
        logic hit1;

        assign hit0 = ctl.push0.en && (CNT_W'(ctl.push0.idx) == CNT_W'(g));
        assign hit1 = ctl.push1.en && (CNT_W'(ctl.push1.idx) == CNT_W'(g));

        assign cell_ctl[g].wr_en     = accept & (hit0 | hit1);
        assign cell_ctl[g].wr_tok    = hit0 ? ctl.push0.tok : ctl.push1.tok;
        assign cell_ctl[g].tok_valid = CNT_W'(g) < ctl.count_n;
        assign cell_ctl[g].origin    = (g == 0);

        // closure and advance both move one position to the right
        if (g == 0) begin : g_head
            assign w_cin[g]    = 1'b0;
            assign w_adv_in[g] = 1'b0;
        end else begin : g_link
            assign w_cin[g]    = w_cout[g-1];
            assign w_adv_in[g] = w_adv[g-1];
        end

        wmm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_row    (row),
            .i_cell   (cell_ctl[g]),
            .i_cin    (w_cin[g]),
            .i_adv    (w_adv_in[g]),
            .o_cout   (w_cout[g]),
            .o_adv    (w_adv[g]),
            .o_at_end (w_at_end[g])
        );
    end

    // only the position right after the last token can be active past the tokens
    assign any_end = |w_at_end;

    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.kind == KIND_SUBJ_END) begin
            r_out.matched       <= any_end & ~ctl.ovf_n;
            r_out.mask_overflow <= ctl.ovf_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_casemap   <= 1'b0;
        end else begin
            if (accept && i_in_data.kind == KIND_SUBJ_END) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_casemap <= i_cfg_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `WMM_ASSERT_NEXT(a_end_gives_result, accept && i_in_data.kind == KIND_SUBJ_END, o_out_valid, "subject end beat produced no result")
    `WMM_ASSERT_IMPL(a_ovf_full, stat.ovf, stat.count == CNT_W'(MAX_MASK_TOKENS), "overflow flagged below token capacity")
    `WMM_ASSERT_NEXT(a_mask_end_closes, accept && i_in_data.kind == KIND_MASK_END, stat.closed && !stat.esc, "mask end left mask open or escape pending")
    `WMM_ASSERT_IMPL(a_ovf_no_match, o_out_valid && o_out_data.mask_overflow, !o_out_data.matched, "match reported on overflowed mask")
    `WMM_ASSERT_NEXT(a_cfg_write, i_cfg_valid, r_casemap == $past(i_cfg_data), "casemap write lost")

endmodule
